FILE: hw/rtl/rmmc_pkg.sv
// ---------------------------------------------------------------------------
// rmmc_pkg: shared types and constants of the robot match mode controller
// Mode and motor codes, configuration indexes, bundled structs and the
// saturating speed negation used by the step logic.
// ---------------------------------------------------------------------------
package rmmc_pkg;

  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int SPEED_W = 9;
  localparam int CIDX_W  = 4;

  typedef logic [TIME_W-1:0]         time_t;
  typedef logic [CFG_W-1:0]          dur_t;
  typedef logic signed [SPEED_W-1:0] speed_t;

  // Most negative speed pattern and its saturated negation.
  localparam speed_t SPEED_MIN = 9'sh100;
  localparam speed_t SPEED_MAX = 9'sd255;

  typedef enum logic [2:0] {
    MODE_STANDBY   = 3'd0,
    MODE_COUNTDOWN = 3'd1,
    MODE_OPENING   = 3'd2,
    MODE_SEARCH    = 3'd3,
    MODE_CHARGE    = 3'd4,
    MODE_RECOVERY  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    MOTOR_STANDBY = 2'd0,
    MOTOR_BRAKE   = 2'd1,
    MOTOR_DRIVE   = 2'd2
  } motor_t;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_COUNTDOWN = 4'd0;
  localparam logic [CIDX_W-1:0] CFG_OPENING   = 4'd1;
  localparam logic [CIDX_W-1:0] CFG_PERSIST   = 4'd2;
  localparam logic [CIDX_W-1:0] CFG_RECOVERY  = 4'd3;
  localparam logic [CIDX_W-1:0] CFG_BACKUP    = 4'd4;
  localparam logic [CIDX_W-1:0] CFG_SEARCH_SP = 4'd5;
  localparam logic [CIDX_W-1:0] CFG_CHARGE_SP = 4'd6;
  localparam logic [CIDX_W-1:0] CFG_SPIN_SP   = 4'd7;

  typedef struct packed {
    dur_t   start_delay_ms;
    dur_t   opening_ms;
    dur_t   persist_ms;
    dur_t   recovery_ms;
    dur_t   backup_ms;
    speed_t search_speed;
    speed_t charge_speed;
    speed_t spin_speed;
  } cfg_t;

  typedef struct packed {
    mode_t mode;
    time_t mode_start_ms;
    time_t loss_start_ms;
    logic  spin_to_left;
  } state_t;

  typedef struct packed {
    logic  button_pressed;
    logic  left_border;
    logic  right_border;
    logic  opponent_seen;
    time_t now_ms;
  } sample_t;

  // Packed so that mode_now sits in the lowest bits.
  typedef struct packed {
    logic   led_on;
    speed_t right_speed;
    speed_t left_speed;
    motor_t motor_mode;
    mode_t  mode_now;
  } result_t;

  // Negation that maps the most negative pattern to the largest positive.
  function automatic speed_t neg_sat(input speed_t v);
    if (v == SPEED_MIN) begin
      return SPEED_MAX;
    end
    return -v;
  endfunction

endpackage

FILE: hw/rtl/rmmc_step.sv
// ---------------------------------------------------------------------------
// rmmc_step: next-state and result logic of the match mode controller
// Combinational: takes the current state, the configuration and one sample,
// and gives the state after the sample together with the result item.
// ---------------------------------------------------------------------------
module rmmc_step #(
  parameter int BLINK_MS      = 256,
  parameter int OPENING_SPEED = 200,
  parameter int BACKUP_SPEED  = -200
) (
  input  rmmc_pkg::state_t  st,
  input  rmmc_pkg::cfg_t    cfg,
  input  rmmc_pkg::sample_t smp,
  output rmmc_pkg::state_t  st_next,
  output rmmc_pkg::result_t res
);

  localparam int BLINK_BIT = $clog2(BLINK_MS);
  localparam rmmc_pkg::speed_t OPEN_SP = rmmc_pkg::speed_t'(OPENING_SPEED);
  localparam rmmc_pkg::speed_t BACK_SP = rmmc_pkg::speed_t'(BACKUP_SPEED);

  rmmc_pkg::time_t el_old;
  rmmc_pkg::time_t el_loss;
  rmmc_pkg::time_t el_new;
  logic            border;

  assign border  = smp.left_border | smp.right_border;
  assign el_old  = smp.now_ms - st.mode_start_ms;
  assign el_loss = smp.now_ms - st.loss_start_ms;

  // Mode transitions; in opening, search and charge, border hits win over all else.
  always_comb begin
    st_next = st;
    unique case (st.mode)
      rmmc_pkg::MODE_COUNTDOWN: begin
        if (el_old >= rmmc_pkg::time_t'(cfg.start_delay_ms)) begin
          st_next.mode          = rmmc_pkg::MODE_OPENING;
          st_next.mode_start_ms = smp.now_ms;
        end
      end
      rmmc_pkg::MODE_OPENING, rmmc_pkg::MODE_SEARCH: begin
        if (border) begin
          st_next.mode          = rmmc_pkg::MODE_RECOVERY;
          st_next.mode_start_ms = smp.now_ms;
          st_next.spin_to_left  = ~smp.left_border;
        end else if (smp.opponent_seen) begin
          st_next.mode          = rmmc_pkg::MODE_CHARGE;
          st_next.mode_start_ms = smp.now_ms;
          st_next.loss_start_ms = '0;
        end else if (st.mode == rmmc_pkg::MODE_OPENING &&
                     el_old >= rmmc_pkg::time_t'(cfg.opening_ms)) begin
          st_next.mode          = rmmc_pkg::MODE_SEARCH;
          st_next.mode_start_ms = smp.now_ms;
        end
      end
      rmmc_pkg::MODE_CHARGE: begin
        if (border) begin
          st_next.mode          = rmmc_pkg::MODE_RECOVERY;
          st_next.mode_start_ms = smp.now_ms;
          st_next.spin_to_left  = ~smp.left_border;
        end else if (smp.opponent_seen) begin
          st_next.loss_start_ms = '0;
        end else if (st.loss_start_ms == '0) begin
          // A loss stamped at time zero reads as not started again.
          st_next.loss_start_ms = smp.now_ms;
        end else if (el_loss >= rmmc_pkg::time_t'(cfg.persist_ms)) begin
          st_next.mode          = rmmc_pkg::MODE_SEARCH;
          st_next.mode_start_ms = smp.now_ms;
          st_next.loss_start_ms = '0;
        end
      end
      rmmc_pkg::MODE_RECOVERY: begin
        if (el_old >= rmmc_pkg::time_t'(cfg.recovery_ms)) begin
          st_next.mode          = rmmc_pkg::MODE_SEARCH;
          st_next.mode_start_ms = smp.now_ms;
        end
      end
      default: begin
        // Standby, and any unused code behaves as standby.
        st_next.mode = rmmc_pkg::MODE_STANDBY;
        if (smp.button_pressed) begin
          st_next.mode          = rmmc_pkg::MODE_COUNTDOWN;
          st_next.mode_start_ms = smp.now_ms;
        end
      end
    endcase
  end

  assign el_new = smp.now_ms - st_next.mode_start_ms;

  // Result for the mode after the transition.
  always_comb begin
    res             = '0;
    res.mode_now    = st_next.mode;
    res.motor_mode  = rmmc_pkg::MOTOR_STANDBY;
    unique case (st_next.mode)
      rmmc_pkg::MODE_COUNTDOWN: begin
        res.motor_mode = rmmc_pkg::MOTOR_BRAKE;
        res.led_on     = el_new[BLINK_BIT];
      end
      rmmc_pkg::MODE_OPENING: begin
        res.motor_mode  = rmmc_pkg::MOTOR_DRIVE;
        res.led_on      = 1'b1;
        res.left_speed  = OPEN_SP;
        res.right_speed = rmmc_pkg::neg_sat(OPEN_SP);
      end
      rmmc_pkg::MODE_SEARCH: begin
        res.motor_mode  = rmmc_pkg::MOTOR_DRIVE;
        res.led_on      = 1'b1;
        res.left_speed  = cfg.search_speed;
        res.right_speed = rmmc_pkg::neg_sat(cfg.search_speed);
      end
      rmmc_pkg::MODE_CHARGE: begin
        res.motor_mode  = rmmc_pkg::MOTOR_DRIVE;
        res.led_on      = 1'b1;
        res.left_speed  = cfg.charge_speed;
        res.right_speed = cfg.charge_speed;
      end
      rmmc_pkg::MODE_RECOVERY: begin
        res.motor_mode = rmmc_pkg::MOTOR_DRIVE;
        res.led_on     = 1'b1;
        if (el_new < rmmc_pkg::time_t'(cfg.backup_ms)) begin
          res.left_speed  = BACK_SP;
          res.right_speed = BACK_SP;
        end else if (st_next.spin_to_left) begin
          res.right_speed = cfg.spin_speed;
          res.left_speed  = rmmc_pkg::neg_sat(cfg.spin_speed);
        end else begin
          res.left_speed  = cfg.spin_speed;
          res.right_speed = rmmc_pkg::neg_sat(cfg.spin_speed);
        end
      end
      default: begin
        res.motor_mode = rmmc_pkg::MOTOR_STANDBY;
      end
    endcase
  end

endmodule

FILE: hw/rtl/robot_match_mode_controller.sv
// ---------------------------------------------------------------------------
// robot_match_mode_controller: six-mode match controller for a small robot
// Samples button, border and opponent sensors with a millisecond stamp and
// gives the mode, motor mode, wheel speeds and LED for each sample.
// ---------------------------------------------------------------------------
//  Channel   Dir  Handshake                      Payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  one sensor sample
//  m_axis    out  m_axis_tvalid / m_axis_tready  one result per sample
//  cfg       in   cfg_valid / cfg_ready          register index and data
//
// A sample is registered at acceptance and its result is loaded into the
// result register when it advances; one sample is taken per cycle while the
// output is not stalled; mode state and result load in the same cycle.
// When the result register is stalled, one more sample is held in the input
// register; the input stalls only when both registers are full.
// Reset restores the default registers and standby; cfg_ready is always high.
// ---------------------------------------------------------------------------
module robot_match_mode_controller #(
  parameter int BLINK_MS      = 256,
  parameter int OPENING_SPEED = 200,
  parameter int BACKUP_SPEED  = -200
) (
  input  logic        clk,
  input  logic        rst,
  // tdata: button_pressed, left_border, right_border, opponent_seen,
  // now_ms[31:0], 4 zero bits
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  // tdata: mode_now[2:0], motor_mode[1:0], left_speed[8:0],
  // right_speed[8:0], led_on
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rmmc_pkg::cfg_t    cfg;
  rmmc_pkg::state_t  st;
  rmmc_pkg::state_t  st_next;
  rmmc_pkg::sample_t smp;
  rmmc_pkg::result_t res;
  rmmc_pkg::result_t res_q;
  logic              smp_valid;
  logic              advance;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_delay_ms <= 16'd5000;
      cfg.opening_ms     <= 16'd300;
      cfg.persist_ms     <= 16'd500;
      cfg.recovery_ms    <= 16'd600;
      cfg.backup_ms      <= 16'd300;
      cfg.search_speed   <= 9'sd120;
      cfg.charge_speed   <= 9'sd255;
      cfg.spin_speed     <= 9'sd180;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rmmc_pkg::CFG_COUNTDOWN: cfg.start_delay_ms <= cfg_data;
        rmmc_pkg::CFG_OPENING:   cfg.opening_ms     <= cfg_data;
        rmmc_pkg::CFG_PERSIST:   cfg.persist_ms     <= cfg_data;
        rmmc_pkg::CFG_RECOVERY:  cfg.recovery_ms    <= cfg_data;
        rmmc_pkg::CFG_BACKUP:    cfg.backup_ms      <= cfg_data;
        rmmc_pkg::CFG_SEARCH_SP: cfg.search_speed   <= cfg_data[8:0];
        rmmc_pkg::CFG_CHARGE_SP: cfg.charge_speed   <= cfg_data[8:0];
        rmmc_pkg::CFG_SPIN_SP:   cfg.spin_speed     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // A held sample moves on when the result register is free or draining.
  assign advance       = smp_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !smp_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (s_axis_tready) begin
      smp_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      smp.button_pressed <= s_axis_tdata[0];
      smp.left_border    <= s_axis_tdata[1];
      smp.right_border   <= s_axis_tdata[2];
      smp.opponent_seen  <= s_axis_tdata[3];
      smp.now_ms         <= s_axis_tdata[35:4];
    end
  end

  rmmc_step #(
    .BLINK_MS      (BLINK_MS),
    .OPENING_SPEED (OPENING_SPEED),
    .BACKUP_SPEED  (BACKUP_SPEED)
  ) u_step (
    .st      (st),
    .cfg     (cfg),
    .smp     (smp),
    .st_next (st_next),
    .res     (res)
  );

  // Mode state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode          <= rmmc_pkg::MODE_STANDBY;
      st.mode_start_ms <= '0;
      st.loss_start_ms <= '0;
      st.spin_to_left  <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tdata = res_q;

  // State moves only together with a request entering the result register.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("mode state changed without an advancing request");

  // The shown mode is the mode left in the state register.
  a_mode_match: assert property (@(posedge clk) disable iff (rst)
    advance |=> (res_q.mode_now == st.mode))
    else $error("result mode differs from stored mode");

  // Entering charge starts with no loss timer.
  a_charge_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && st_next.mode == rmmc_pkg::MODE_CHARGE &&
     st.mode != rmmc_pkg::MODE_CHARGE) |=> (st.loss_start_ms == '0))
    else $error("loss timer not cleared on entering charge");

  // Standby results keep the motors and LED off.
  a_standby_out: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res_q.mode_now == rmmc_pkg::MODE_STANDBY) |->
    (!res_q.led_on && res_q.motor_mode == rmmc_pkg::MOTOR_STANDBY))
    else $error("standby result drives motors or LED");

endmodule
